// ===== design/tbse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tbse_pkg
// Shared types and constants for the two-button setpoint editor.
// ============================================================================
package tbse_pkg;

    // Setpoint word width and stream widths.
    localparam int DATA_W     = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 72;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_CURRENT = 2'd0;
    localparam logic [1:0] REG_STEP_MIN    = 2'd1;
    localparam logic [1:0] REG_STEP_MAX    = 2'd2;

    // Page codes, also the slot of each setpoint in the value array.
    localparam logic [1:0] PAGE_CURRENT = 2'd0;
    localparam logic [1:0] PAGE_RESIST  = 2'd1;
    localparam logic [1:0] PAGE_POWER   = 2'd2;
    localparam logic [1:0] PAGE_TRIGGER = 2'd3;

    // Reset values of the configuration registers and setpoints.
    localparam logic [DATA_W-1:0] MIN_CURRENT_RESET = 16'd5;
    localparam logic [DATA_W-1:0] STEP_MIN_RESET    = 16'd1;
    localparam logic [DATA_W-1:0] STEP_MAX_RESET    = 16'd100;
    localparam logic [DATA_W-1:0] RESIST_RESET      = 16'd1000;

    // Hold and step behavior.
    localparam logic [1:0]        BOTH_LONG  = 2'd3;
    localparam logic [2:0]        HOLD_LIMIT = 3'd3;
    localparam logic [2:0]        HOLD_MAX   = 3'd4;
    localparam logic [DATA_W:0]   STEP_GROW  = 17'd5;

    // Division by ten as a reciprocal multiply: exact for dividends below 2^18.
    localparam logic [15:0] DIV10_MULT  = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef logic [3:0][DATA_W-1:0] values_t;

    typedef struct packed {
        logic [DATA_W-1:0] min_current;
        logic [DATA_W-1:0] step_min;
        logic [DATA_W-1:0] step_max;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        page;
        values_t           values;
        logic [1:0]        both_cnt;
        logic [2:0]        hold_cnt;
        logic [DATA_W-1:0] step;
        logic              led;
    } state_t;

    typedef struct packed {
        values_t    values;
        logic [1:0] page;
        logic       changed;
        logic       led;
        logic       clear;
    } result_t;

endpackage

// ===== design/two_button_setpoint_editor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// two_button_setpoint_editor
// Button-driven editor of four setpoints with page selection and hold reset.
// ============================================================================
// Pipeline: an accepted word is held in the input register, and its result
// is taken into the output register, from which it is offered.
// Throughput: one word per cycle unless m_tready stalls; the state update is a
// single pass of logic between the input register and the output register.
// Reset: synchronous active-low; clears both pipeline valid flags, restores the
// configuration registers and all setpoint state to their reset values.
module two_button_setpoint_editor (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [tbse_pkg::DATA_W-1:0]        cfg_wr_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [0] button_up, [1] button_down, [17:2] measured_mv, [23:18] zero
    input  logic [tbse_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [15:0] current_setpoint, [31:16] resistance_setpoint,
    // [47:32] power_setpoint, [63:48] trigger_setpoint, [65:64] page_now,
    // [66] changed, [67] led_on, [68] clear_energy, [71:69] zero
    output logic [tbse_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tbse_pkg::*;

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    result_t           res_next;
    result_t           out_data_reg;
    logic              out_valid_reg;
    logic              in_valid_reg;
    logic              in_up_reg;
    logic              in_down_reg;
    logic [DATA_W-1:0] in_mv_reg;
    logic [DATA_W-1:0] trigger;
    logic              advance;

    // Pipeline flow: the output register takes a word when empty or drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_current <= MIN_CURRENT_RESET;
            cfg_reg.step_min    <= STEP_MIN_RESET;
            cfg_reg.step_max    <= STEP_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_CURRENT: cfg_reg.min_current <= cfg_wr_data;
                REG_STEP_MIN:    cfg_reg.step_min    <= cfg_wr_data;
                REG_STEP_MAX:    cfg_reg.step_max    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_up_reg   <= s_tdata[0];
            in_down_reg <= s_tdata[1];
            in_mv_reg   <= s_tdata[DATA_W+1:2];
        end
    end

    tbse_trigger_calc u_trigger (
        .mv      (in_mv_reg),
        .trigger (trigger)
    );

    tbse_step_logic u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .up      (in_up_reg),
        .down    (in_down_reg),
        .trigger (trigger),
        .st_next (state_next),
        .res     (res_next)
    );

    // Editor state advances once per word moved to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.page                 <= PAGE_CURRENT;
            state_reg.values[PAGE_CURRENT] <= MIN_CURRENT_RESET;
            state_reg.values[PAGE_RESIST]  <= RESIST_RESET;
            state_reg.values[PAGE_POWER]   <= '0;
            state_reg.values[PAGE_TRIGGER] <= '0;
            state_reg.both_cnt             <= 2'd0;
            state_reg.hold_cnt             <= 3'd0;
            state_reg.step                 <= STEP_MIN_RESET;
            state_reg.led                  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.clear, out_data_reg.led,
                       out_data_reg.changed, out_data_reg.page,
                       out_data_reg.values[PAGE_TRIGGER],
                       out_data_reg.values[PAGE_POWER],
                       out_data_reg.values[PAGE_RESIST],
                       out_data_reg.values[PAGE_CURRENT]};

`ifndef NO_ASSERTIONS
    // A released tick always turns the LED off.
    a_led_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_up_reg && !in_down_reg) |=> !state_reg.led)
        else $error("LED not cleared after an idle tick");

    // A both-button tick restarts the hold count at one.
    a_both_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_up_reg && in_down_reg) |=> (state_reg.hold_cnt == 3'd1))
        else $error("hold count wrong after a both-button tick");

    // The hold count never passes its ceiling.
    a_hold_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hold_cnt <= HOLD_MAX)
        else $error("hold count above its ceiling");

    // A long-hold reset leaves the both-hold counter cleared.
    a_clear_both: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.clear) |=> (state_reg.both_cnt == 2'd0))
        else $error("both-hold count not cleared on reset tick");

    // No result appears without a word in the input register.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg && (!out_valid_reg || m_tready)) |=> !m_tvalid)
        else $error("result word without a source word");
`endif

endmodule

// ===== design/tbse_trigger_calc.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tbse_trigger_calc
// Computes floor(mv * 9 / 10) as mv - ceil(mv / 10) with a reciprocal multiply.
// ============================================================================
module tbse_trigger_calc (
    input  logic [tbse_pkg::DATA_W-1:0] mv,
    output logic [tbse_pkg::DATA_W-1:0] trigger
);
    import tbse_pkg::*;

    logic [DATA_W:0]     dividend;
    logic [2*DATA_W:0]   product;
    logic [DATA_W-1:0]   tenth;

    // ceil(mv / 10) is floor((mv + 9) / 10).
    assign dividend = {1'b0, mv} + 17'd9;
    assign product  = dividend * DIV10_MULT;
    assign tenth    = {2'b00, product[2*DATA_W:DIV10_SHIFT]};
    assign trigger  = mv - tenth;

endmodule

// ===== design/tbse_step_logic.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tbse_step_logic
// Next-state and result logic for one polling tick of the editor.
// ============================================================================
module tbse_step_logic (
    input  tbse_pkg::cfg_t                  cfg,
    input  tbse_pkg::state_t                st,
    input  logic                            up,
    input  logic                            down,
    input  logic [tbse_pkg::DATA_W-1:0]     trigger,
    output tbse_pkg::state_t                st_next,
    output tbse_pkg::result_t               res
);
    import tbse_pkg::*;

    always_comb begin
        state_t            nxt;
        values_t           v;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W:0]   sum;
        logic [DATA_W:0]   grow;
        logic [2:0]        hc;
        logic              both;
        logic              any;
        logic              changed;
        logic              clr;

        nxt     = st;
        v       = st.values;
        both    = up & down;
        any     = up | down;
        changed = 1'b0;
        clr     = 1'b0;
        hc      = st.hold_cnt;
        sum     = '0;
        grow    = '0;

        // Both-button hold counting and the release action.
        if (both) begin
            if (st.both_cnt < BOTH_LONG) begin
                nxt.both_cnt = st.both_cnt + 2'd1;
            end
        end else begin
            if (st.both_cnt != 2'd0) begin
                if (st.both_cnt < BOTH_LONG) begin
                    nxt.page = st.page + 2'd1;
                end else begin
                    v[PAGE_RESIST]  = RESIST_RESET;
                    v[PAGE_TRIGGER] = trigger;
                    v[PAGE_CURRENT] = cfg.min_current;
                    v[PAGE_POWER]   = '0;
                    clr             = 1'b1;
                end
                changed = 1'b1;
            end
            nxt.both_cnt = 2'd0;
        end

        // Single-button edit of the page selected at the start of the tick.
        tgt = v[st.page];
        if (up && !down) begin
            sum = {1'b0, tgt} + {1'b0, st.step};
            v[st.page] = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
        end
        if (down && !up) begin
            v[st.page] = (st.step < tgt) ? (tgt - st.step) : '0;
        end

        // Hold tracking, step acceleration and the LED.
        if (any) begin
            nxt.led = ~st.led;
            changed = 1'b1;
            hc      = (both ? 3'd0 : st.hold_cnt) + 3'd1;
            if (hc > HOLD_LIMIT) begin
                hc = HOLD_MAX;
                if (st.step < cfg.step_max) begin
                    grow     = {1'b0, st.step} + STEP_GROW;
                    nxt.step = grow[DATA_W] ? {DATA_W{1'b1}} : grow[DATA_W-1:0];
                end
            end
            nxt.hold_cnt = hc;
        end else begin
            nxt.hold_cnt = 3'd0;
            nxt.step     = cfg.step_min;
            nxt.led      = 1'b0;
        end

        // The current setpoint never drops below its lower clamp.
        if (v[PAGE_CURRENT] <= cfg.min_current) begin
            v[PAGE_CURRENT] = cfg.min_current;
        end

        nxt.values  = v;
        st_next     = nxt;
        res.values  = v;
        res.page    = nxt.page;
        res.changed = changed;
        res.led     = nxt.led;
        res.clear   = clr;
    end

endmodule

// ===== test/two_button_setpoint_editor_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// two_button_setpoint_editor_test
// Self-checking bench for the two-button setpoint editor. Polling ticks are
// streamed in with random bursts and gaps, and results are drained under a
// changing stall pattern. A behavioral model of the editor predicts every
// result word, and each word is checked field by field. Runs cover directed
// corner cases, several register settings and a long output hold-off.
// ============================================================================
module two_button_setpoint_editor_test;

    import tbse_pkg::*;

    localparam int         CLK_HALF    = 4;
    localparam int         CYCLE_LIMIT = 250000;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #(CLK_HALF) aclk = ~aclk;

    // Block ports.
    logic                  cfg_wr_en   = 1'b0;
    logic [1:0]            cfg_index   = REG_MIN_CURRENT;
    logic [DATA_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    two_button_setpoint_editor uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Editor model: registers and state as the block should hold them.
    logic [DATA_W-1:0] cfg_min_current = MIN_CURRENT_RESET;
    logic [DATA_W-1:0] cfg_step_min    = STEP_MIN_RESET;
    logic [DATA_W-1:0] cfg_step_max    = STEP_MAX_RESET;

    logic [1:0]        ed_page = PAGE_CURRENT;
    values_t           ed_sp;
    logic [1:0]        ed_both = '0;
    logic [2:0]        ed_hold = '0;
    logic [DATA_W-1:0] ed_step = STEP_MIN_RESET;
    logic              ed_led  = 1'b0;

    result_t expected_ticks[$];
    int      mismatches  = 0;
    int      burst_left  = 0;
    int      hold_req_id = 0;
    int      cycle_count = 0;

    initial begin
        ed_sp[PAGE_CURRENT] = MIN_CURRENT_RESET;
        ed_sp[PAGE_RESIST]  = RESIST_RESET;
        ed_sp[PAGE_POWER]   = '0;
        ed_sp[PAGE_TRIGGER] = '0;
    end

    // Advance the model by one tick and return the word it should produce.
    function automatic result_t predict_tick(input logic up, input logic dn,
                                             input logic [DATA_W-1:0] mv);
        result_t     r;
        logic [1:0]  tgt;
        logic [16:0] sum;
        int unsigned scaled;
        tgt       = ed_page;
        r.changed = 1'b0;
        r.clear   = 1'b0;

        // Both-button hold counting and release handling.
        if (up && dn) begin
            if (ed_both < BOTH_LONG) ed_both = ed_both + 2'd1;
            ed_hold = '0;
        end else begin
            if (ed_both != 2'd0) begin
                if (ed_both < BOTH_LONG) begin
                    ed_page = ed_page + 2'd1;
                end else begin
                    scaled              = 32'(mv) * 9;
                    ed_sp[PAGE_RESIST]  = RESIST_RESET;
                    ed_sp[PAGE_TRIGGER] = DATA_W'(scaled / 10);
                    ed_sp[PAGE_CURRENT] = cfg_min_current;
                    ed_sp[PAGE_POWER]   = '0;
                    r.clear             = 1'b1;
                end
                r.changed = 1'b1;
            end
            ed_both = '0;
        end

        // Single-button edit of the page selected at the start of the tick.
        if (up && !dn) begin
            sum        = {1'b0, ed_sp[tgt]} + {1'b0, ed_step};
            ed_sp[tgt] = sum[16] ? 16'hFFFF : sum[15:0];
        end
        if (dn && !up) begin
            ed_sp[tgt] = (ed_step < ed_sp[tgt]) ? ed_sp[tgt] - ed_step : '0;
        end

        // Hold acceleration and the LED.
        if (up || dn) begin
            ed_led    = ~ed_led;
            r.changed = 1'b1;
            ed_hold   = ed_hold + 3'd1;
            if (ed_hold > HOLD_LIMIT) begin
                ed_hold = HOLD_MAX;
                if (ed_step < cfg_step_max) begin
                    sum     = {1'b0, ed_step} + STEP_GROW;
                    ed_step = sum[16] ? 16'hFFFF : sum[15:0];
                end
            end
        end else begin
            ed_hold = '0;
            ed_step = cfg_step_min;
            ed_led  = 1'b0;
        end

        if (ed_sp[PAGE_CURRENT] <= cfg_min_current) ed_sp[PAGE_CURRENT] = cfg_min_current;

        r.values = ed_sp;
        r.page   = ed_page;
        r.led    = ed_led;
        return r;
    endfunction

    // Offer one tick word, with the sender idling between bursts.
    task automatic send_tick(input logic up, input logic dn, input logic [DATA_W-1:0] mv);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, mv, dn, up};
        do @(posedge aclk); while (!s_tready);
        expected_ticks.push_back(predict_tick(up, dn, mv));
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic settle_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_CURRENT: cfg_min_current = data;
            REG_STEP_MIN:    cfg_step_min    = data;
            REG_STEP_MAX:    cfg_step_max    = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] min_cur, input logic [DATA_W-1:0] smin,
                              input logic [DATA_W-1:0] smax);
        settle_idle();
        write_reg(REG_MIN_CURRENT, min_cur);
        write_reg(REG_STEP_MIN, smin);
        write_reg(REG_STEP_MAX, smax);
    endtask

    // Voltage with extra weight on the two ends of the range.
    function automatic logic [DATA_W-1:0] rand_mv();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // One button gesture with random content; returns the number of ticks sent.
    task automatic run_gesture(output int sent);
        int   kind;
        int   len;
        logic b;
        sent = 0;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            // Single-button hold, then a short release.
            b   = 1'($urandom_range(0, 1));
            len = $urandom_range(1, 10);
            repeat (len) send_tick(b, ~b, rand_mv());
            sent = len;
            len  = $urandom_range(0, 2);
            repeat (len) send_tick(1'b0, 1'b0, rand_mv());
            sent += len;
        end else if (kind <= 6) begin
            // Both-button hold, short or long, released to none or to one button.
            len = (kind <= 4) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            repeat (len) send_tick(1'b1, 1'b1, rand_mv());
            b = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) send_tick(1'b0, 1'b0, rand_mv());
            else send_tick(b, ~b, rand_mv());
            sent = len + 1;
        end else if (kind == 7) begin
            len = $urandom_range(1, 4);
            repeat (len) send_tick(1'b0, 1'b0, rand_mv());
            sent = len;
        end else begin
            // Noise: unrelated button levels.
            len = $urandom_range(1, 6);
            repeat (len) send_tick(1'($urandom()), 1'($urandom()), rand_mv());
            sent = len;
        end
    endtask

    // Directed walk through editing, paging and both resets.
    task automatic test_editing();
        // Reset state seen through an idle tick.
        send_tick(1'b0, 1'b0, 16'h0000);
        // Down at the floor stays clamped to the minimum current.
        send_tick(1'b0, 1'b1, 16'hFFFF);
        // A long up hold, after the down tick, grows the step from its third tick on.
        repeat (6) send_tick(1'b1, 1'b0, rand_mv());
        send_tick(1'b0, 1'b0, rand_mv());
        // Short both-hold moves to the resistance page.
        send_tick(1'b1, 1'b1, rand_mv());
        send_tick(1'b0, 1'b0, rand_mv());
        send_tick(1'b0, 1'b1, rand_mv());
        // Long both-hold resets the setpoints with the top voltage.
        repeat (3) send_tick(1'b1, 1'b1, rand_mv());
        send_tick(1'b0, 1'b0, 16'hFFFF);
        // Long hold released with one button still down: reset, then edit.
        repeat (4) send_tick(1'b1, 1'b1, rand_mv());
        send_tick(1'b1, 1'b0, 16'd12345);
        // Short hold released into the other button.
        send_tick(1'b1, 1'b1, rand_mv());
        send_tick(1'b0, 1'b1, 16'h0000);
    endtask

    // Register extremes: saturation at the top, floor at zero, step overflow.
    task automatic test_config_extremes();
        set_config(16'd5, 16'hFFFF, 16'hFFFF);
        send_tick(1'b0, 1'b0, rand_mv());
        repeat (2) send_tick(1'b1, 1'b0, rand_mv());
        send_tick(1'b0, 1'b1, rand_mv());
        // A write to the unused index must leave every register alone.
        settle_idle();
        write_reg(REG_UNUSED, 16'h0000);
        send_tick(1'b0, 1'b0, rand_mv());
        set_config(16'd0, 16'd65533, 16'hFFFF);
        send_tick(1'b0, 1'b0, rand_mv());
        repeat (6) send_tick(1'b0, 1'b1, rand_mv());
        send_tick(1'b0, 1'b0, rand_mv());
        set_config(16'hFFFF, 16'd1, 16'd1);
        repeat (5) send_tick(1'b1, 1'b0, rand_mv());
        send_tick(1'b0, 1'b0, rand_mv());
    endtask

    // The receiver holds off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        int n;
        int count;
        set_config(MIN_CURRENT_RESET, STEP_MIN_RESET, STEP_MAX_RESET);
        hold_req_id++;
        count = 0;
        while (count < 60) begin
            run_gesture(n);
            count += n;
        end
    endtask

    // Random gestures under a series of register settings.
    task automatic test_random_gestures();
        int n;
        int count;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(MIN_CURRENT_RESET, STEP_MIN_RESET, STEP_MAX_RESET);
                1: set_config(16'd0, 16'd1, 16'hFFFF);
                2: set_config(16'hFFFF, 16'hFFFF, 16'd1);
                3: set_config(16'd100, 16'd65531, 16'hFFFF);
                4: set_config(16'($urandom_range(0, 2000)), 16'($urandom_range(1, 300)),
                              16'($urandom_range(1, 3000)));
                default: set_config(16'($urandom()), 16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)));
            endcase
            count = 0;
            while (count < 280) begin
                run_gesture(n);
                count += n;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_editing();
        test_config_extremes();
        test_backpressure();
        test_random_gestures();
        settle_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver stall pattern, with a long hold-off on request.
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    int rx_hold_ack  = 0;

    always @(posedge aclk) begin
        if (rx_hold_ack != hold_req_id) begin
            rx_hold_ack  <= hold_req_id;
            rx_hold_left <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(8, 60);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: each accepted word against the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ticks.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0h", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("current_setpoint", want.values[PAGE_CURRENT], m_tdata[15:0]);
                check_field("resistance_setpoint", want.values[PAGE_RESIST], m_tdata[31:16]);
                check_field("power_setpoint", want.values[PAGE_POWER], m_tdata[47:32]);
                check_field("trigger_setpoint", want.values[PAGE_TRIGGER], m_tdata[63:48]);
                check_field("page_now", 16'(want.page), 16'(m_tdata[65:64]));
                check_field("changed", 16'(want.changed), 16'(m_tdata[66]));
                check_field("led_on", 16'(want.led), 16'(m_tdata[67]));
                check_field("clear_energy", 16'(want.clear), 16'(m_tdata[68]));
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/tbse_pkg.sv
design/tbse_trigger_calc.sv
design/tbse_step_logic.sv
design/two_button_setpoint_editor.sv
test/two_button_setpoint_editor_test.sv
